[src/efdg_pkg.sv]
// ----------------------------------------------------------------------------
// efdg_pkg
// Shared types, codes and constants of the enrollment frame diversity gate.
// ----------------------------------------------------------------------------
package efdg_pkg;

    // Default sizing of the frame store
    localparam int FRAME_PIXELS_DEF = 5120;
    localparam int MAX_SLOTS_DEF    = 8;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int MIN_DIFF_W = 12;
    localparam int STAGES_W   = 4;
    localparam int DUP_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int COUNT_W    = 4;

    // Register reset values
    localparam logic [MIN_DIFF_W-1:0] MIN_DIFF_RST   = 12'd128;
    localparam logic [STAGES_W-1:0]   MIN_STAGES_RST = 4'd3;
    localparam logic [DUP_W-1:0]      DUP_STOP_RST   = 3'd2;

    // Duplicate streak saturates here
    localparam logic [DUP_W-1:0] STREAK_MAX = 3'd7;

    // Input operation codes
    localparam logic OP_PIXEL   = 1'b0;
    localparam logic OP_SESSION = 1'b1;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DIFF   = 2'd0,
        CFG_MIN_STAGES = 2'd1,
        CFG_DUP_STOP   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        VERDICT_STORED    = 2'd0,
        VERDICT_UNSTORED  = 2'd1,
        VERDICT_RETRY     = 2'd2,
        VERDICT_CONVERGED = 2'd3
    } t_verdict;

    // Configuration register set
    typedef struct packed {
        logic [MIN_DIFF_W-1:0] min_diff_q4;
        logic [STAGES_W-1:0]   min_stages;
        logic [DUP_W-1:0]      dup_stop;
    } t_cfg;

    // Token moving down the cell chain, one per accepted item
    typedef struct packed {
        logic   valid;
        logic   sess;    // session start
        logic   enroll;  // enroll flag carried by a session start
        logic   last;    // final pixel of the frame
        logic   cmp;     // pixel lies inside the frame store
        logic   dup;     // some held slot matched so far
        t_pixel pixel;
    } t_tok;

endpackage

[src/efdg_in_if.sv]
// ----------------------------------------------------------------------------
// efdg_in_if
// Pixel and session-start channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface efdg_in_if import efdg_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   op;
    t_pixel pixel;
    logic   frame_end;
    logic   enroll_session;

    modport source (output valid, output op, output pixel, output frame_end,
                    output enroll_session, input ready);
    modport sink   (input valid, input op, input pixel, input frame_end,
                    input enroll_session, output ready);
endinterface

[src/efdg_out_if.sv]
// ----------------------------------------------------------------------------
// efdg_out_if
// Verdict channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface efdg_out_if import efdg_pkg::*; ();
    logic               valid;
    logic               ready;
    t_verdict           verdict;
    logic [COUNT_W-1:0] stage_goal;
    logic [COUNT_W-1:0] stored_count;

    modport source (output valid, output verdict, output stage_goal,
                    output stored_count, input ready);
    modport sink   (input valid, input verdict, input stage_goal,
                    input stored_count, output ready);
endinterface

[src/enroll_frame_diversity_gate.sv]
// ----------------------------------------------------------------------------
// enroll_frame_diversity_gate
// Compares each sensor frame against the stored enrollment frames and issues
// a store, deliver, retry or converge verdict at the end of every frame.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while a frame streams. Each pixel walks a
// row of MAX_SLOTS slot cells, each a read of the slot memory, then a
// difference and accumulate, and the verdict is decided at the end of the
// row; from the final pixel until the verdict is loaded into the output
// register the input is held off (same for a session start). The verdict
// waits in its output register while the next frame streams in. The frame
// store needs no clearing after reset: the contents of a slot are used only
// after it has been written by an accepted frame.
module enroll_frame_diversity_gate import efdg_pkg::*; #(
    parameter int FRAME_PIXELS = FRAME_PIXELS_DEF,
    parameter int MAX_SLOTS    = MAX_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    efdg_in_if.sink               i_in,
    efdg_out_if.source            o_out
);

    localparam int IDX_W  = $clog2(FRAME_PIXELS);
    localparam int CNT_W  = $clog2(FRAME_PIXELS + 1);
    localparam int RHS_W  = MIN_DIFF_W + CNT_W;
    localparam int SLOT_W = $clog2(MAX_SLOTS + 1);

    t_cfg              r_cfg;
    logic              r_busy, n_busy;
    logic [CNT_W-1:0]  r_pix_idx, n_pix_idx;
    t_tok              r_s0_tok, n_s0_tok;
    logic [IDX_W-1:0]  r_s0_idx;
    logic [RHS_W-1:0]  r_s0_rhs;

    logic              w_xfer;
    logic              w_sess;
    logic              w_cmp;
    logic [CNT_W-1:0]  w_count;
    logic [RHS_W-1:0]  w_rhs;
    logic [SLOT_W-1:0] w_stored;
    logic              w_done;

    t_tok              w_tok [MAX_SLOTS+1];
    logic [IDX_W-1:0]  w_idx [MAX_SLOTS];
    logic [RHS_W-1:0]  w_rhs_c [MAX_SLOTS];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_diff_q4 <= MIN_DIFF_RST;
            r_cfg.min_stages  <= MIN_STAGES_RST;
            r_cfg.dup_stop    <= DUP_STOP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_DIFF:   r_cfg.min_diff_q4 <= i_cfg_data[MIN_DIFF_W-1:0];
                CFG_MIN_STAGES: r_cfg.min_stages  <= i_cfg_data[STAGES_W-1:0];
                CFG_DUP_STOP:   r_cfg.dup_stop    <= i_cfg_data[DUP_W-1:0];
                default: ;
            endcase
        end
    end

    // Input transfer; hold off after a frame or session boundary
    assign i_in.ready = ~r_busy;
    assign w_xfer     = i_in.valid & ~r_busy;
    assign w_sess     = (i_in.op == OP_SESSION);

    // Pixel position, compared count and threshold product
    assign w_cmp   = (r_pix_idx < CNT_W'(FRAME_PIXELS));
    assign w_count = r_pix_idx + CNT_W'(w_cmp);
    assign w_rhs   = RHS_W'(r_cfg.min_diff_q4) * RHS_W'(w_count);

    always_comb begin
        n_pix_idx = r_pix_idx;
        n_busy    = r_busy;
        if (w_xfer) begin
            if (w_sess || i_in.frame_end) begin
                n_pix_idx = '0;
                n_busy    = 1'b1;
            end else if (w_cmp) begin
                n_pix_idx = r_pix_idx + CNT_W'(1);
            end
        end else if (w_done) begin
            n_busy = 1'b0;
        end

        n_s0_tok.valid  = w_xfer;
        n_s0_tok.sess   = w_sess;
        n_s0_tok.enroll = i_in.enroll_session;
        n_s0_tok.last   = ~w_sess & i_in.frame_end;
        n_s0_tok.cmp    = ~w_sess & w_cmp;
        n_s0_tok.dup    = 1'b0;
        n_s0_tok.pixel  = i_in.pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_pix_idx <= '0;
            r_s0_tok  <= '0;
        end else begin
            r_busy    <= n_busy;
            r_pix_idx <= n_pix_idx;
            r_s0_tok  <= n_s0_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_idx <= r_pix_idx[IDX_W-1:0];
        r_s0_rhs <= w_rhs;
    end

    assign w_tok[0]   = r_s0_tok;
    assign w_idx[0]   = r_s0_idx;
    assign w_rhs_c[0] = r_s0_rhs;

    // Row of slot cells
    for (genvar s = 0; s < MAX_SLOTS; s++) begin : g_cell
        localparam logic [SLOT_W-1:0] SLOT = SLOT_W'(s);
        logic w_held, w_wr_en;
        assign w_held  = (SLOT < w_stored);
        assign w_wr_en = (SLOT == w_stored);

        if (s < MAX_SLOTS - 1) begin : g_mid
            efdg_cell #(.FRAME_PIXELS(FRAME_PIXELS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (w_tok[s]),
                .i_idx   (w_idx[s]),
                .i_rhs   (w_rhs_c[s]),
                .i_held  (w_held),
                .i_wr_en (w_wr_en),
                .o_tok   (w_tok[s+1]),
                .o_idx   (w_idx[s+1]),
                .o_rhs   (w_rhs_c[s+1])
            );
        end else begin : g_tail
            efdg_cell #(.FRAME_PIXELS(FRAME_PIXELS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (w_tok[s]),
                .i_idx   (w_idx[s]),
                .i_rhs   (w_rhs_c[s]),
                .i_held  (w_held),
                .i_wr_en (w_wr_en),
                .o_tok   (w_tok[s+1]),
                .o_idx   (),
                .o_rhs   ()
            );
        end
    end

    // Verdict and session state
    efdg_verdict #(.MAX_SLOTS(MAX_SLOTS)) u_verdict (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tok    (w_tok[MAX_SLOTS]),
        .i_cfg    (r_cfg),
        .o_stored (w_stored),
        .o_done   (w_done),
        .o_out    (o_out)
    );

endmodule

[src/efdg_cell.sv]
// ----------------------------------------------------------------------------
// efdg_cell
// One frame slot: holds a stored frame, accumulates the absolute difference
// against the incoming frame and hands the token to the next slot.
// ----------------------------------------------------------------------------
module efdg_cell import efdg_pkg::*; #(
    parameter  int FRAME_PIXELS = FRAME_PIXELS_DEF,
    localparam int IDX_W        = $clog2(FRAME_PIXELS),
    localparam int CNT_W        = $clog2(FRAME_PIXELS + 1),
    localparam int SUM_W        = PIX_W + CNT_W,
    localparam int RHS_W        = MIN_DIFF_W + CNT_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tok             i_tok,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [RHS_W-1:0] i_rhs,
    input  logic             i_held,   // slot holds an accepted frame
    input  logic             i_wr_en,  // slot is the next free one
    output t_tok             o_tok,
    output logic [IDX_W-1:0] o_idx,
    output logic [RHS_W-1:0] o_rhs
);

    t_tok             r_a_tok, r_b_tok;
    logic [IDX_W-1:0] r_a_idx, r_b_idx;
    logic [RHS_W-1:0] r_a_rhs, r_b_rhs;
    t_pixel           r_mem [FRAME_PIXELS];
    t_pixel           r_rd;
    logic [SUM_W-1:0] r_sum, n_sum;

    logic             w_wr;
    logic             w_acc;
    logic             w_hit;
    t_pixel           w_diff;
    logic [SUM_W-1:0] w_sum;

    // Advance the token through the two cell stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tok <= '0;
            r_b_tok <= '0;
        end else begin
            r_a_tok <= i_tok;
            r_b_tok <= r_a_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_idx <= i_idx;
        r_b_idx <= r_a_idx;
        r_a_rhs <= i_rhs;
        r_b_rhs <= r_a_rhs;
    end

    // Store the pixel when this slot is being filled; read the held pixel
    assign w_wr = i_wr_en & r_a_tok.valid & ~r_a_tok.sess & r_a_tok.cmp;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_a_idx] <= r_a_tok.pixel;
        end
        r_rd <= r_mem[r_a_idx];
    end

    // Accumulate the difference and test the mean on the final pixel
    always_comb begin
        w_diff = (r_b_tok.pixel > r_rd) ? (r_b_tok.pixel - r_rd) : (r_rd - r_b_tok.pixel);
        w_acc  = i_held & r_b_tok.valid & ~r_b_tok.sess & r_b_tok.cmp;
        w_sum  = r_sum + (w_acc ? SUM_W'(w_diff) : '0);
        w_hit  = i_held & r_b_tok.valid & ~r_b_tok.sess & r_b_tok.last &
                 ({w_sum, 4'b0000} < r_b_rhs);
    end

    // Clear the sum at every frame boundary
    always_comb begin
        if (r_b_tok.valid && (r_b_tok.sess || r_b_tok.last)) begin
            n_sum = '0;
        end else begin
            n_sum = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    // Hand the token on with the duplicate flag merged
    always_comb begin
        o_tok     = r_b_tok;
        o_tok.dup = r_b_tok.dup | w_hit;
    end

    assign o_idx = r_b_idx;
    assign o_rhs = r_b_rhs;

endmodule

[src/efdg_verdict.sv]
// ----------------------------------------------------------------------------
// efdg_verdict
// Session state and verdict logic at the end of the cell chain, with the
// output register of the verdict channel.
// ----------------------------------------------------------------------------
module efdg_verdict import efdg_pkg::*; #(
    parameter  int MAX_SLOTS = MAX_SLOTS_DEF,
    localparam int SLOT_W    = $clog2(MAX_SLOTS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tok              i_tok,
    input  t_cfg              i_cfg,
    output logic [SLOT_W-1:0] o_stored,
    output logic              o_done,
    efdg_out_if.source        o_out
);

    localparam int CMP_W = (SLOT_W > STAGES_W) ? SLOT_W : STAGES_W;

    logic               r_pend, n_pend;
    logic               r_pend_sess, r_pend_enroll, r_pend_dup;
    logic [SLOT_W-1:0]  r_stored, n_stored;
    logic [DUP_W-1:0]   r_streak, n_streak;
    logic               r_conv, n_conv;
    logic               r_enroll, n_enroll;
    logic               r_out_valid, n_out_valid;
    t_verdict           r_out_verdict, n_out_verdict;
    logic [COUNT_W-1:0] r_out_target, n_out_target;
    logic [COUNT_W-1:0] r_out_count, n_out_count;

    logic               w_end;
    logic               w_free;
    logic               w_fire_sess;
    logic               w_fire_frame;
    logic [DUP_W-1:0]   w_streak_inc;
    logic               w_conv_ok;

    assign w_end        = i_tok.valid & (i_tok.sess | i_tok.last);
    assign w_free       = ~r_out_valid | o_out.ready;
    assign w_fire_sess  = r_pend & r_pend_sess;
    assign w_fire_frame = r_pend & ~r_pend_sess & w_free;
    assign o_done       = w_fire_sess | w_fire_frame;

    assign w_streak_inc = (r_streak < STREAK_MAX) ? (r_streak + 3'd1) : r_streak;
    assign w_conv_ok    = (CMP_W'(r_stored) >= CMP_W'(i_cfg.min_stages)) &&
                          (r_stored < SLOT_W'(MAX_SLOTS)) &&
                          (w_streak_inc >= i_cfg.dup_stop);

    // Decide the verdict and update the session state
    always_comb begin
        n_pend        = r_pend;
        n_stored      = r_stored;
        n_streak      = r_streak;
        n_conv        = r_conv;
        n_enroll      = r_enroll;
        n_out_valid   = r_out_valid & ~o_out.ready;
        n_out_verdict = r_out_verdict;
        n_out_target  = r_out_target;
        n_out_count   = r_out_count;

        if (w_end) begin
            n_pend = 1'b1;
        end else if (o_done) begin
            n_pend = 1'b0;
        end

        if (w_fire_sess) begin
            n_enroll = r_pend_enroll;
            n_stored = '0;
            n_streak = '0;
            n_conv   = 1'b0;
        end

        if (w_fire_frame) begin
            n_out_valid   = 1'b1;
            n_out_target  = '0;
            n_out_verdict = VERDICT_UNSTORED;
            if (r_enroll && !r_conv) begin
                if (r_pend_dup) begin
                    n_streak = w_streak_inc;
                    if (w_conv_ok) begin
                        n_conv        = 1'b1;
                        n_out_verdict = VERDICT_CONVERGED;
                        n_out_target  = COUNT_W'(r_stored + SLOT_W'(1));
                    end else begin
                        n_out_verdict = VERDICT_RETRY;
                    end
                end else begin
                    n_streak = '0;
                    if (r_stored < SLOT_W'(MAX_SLOTS)) begin
                        n_stored      = r_stored + SLOT_W'(1);
                        n_out_verdict = VERDICT_STORED;
                    end
                end
            end
            n_out_count = COUNT_W'(n_stored);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_stored    <= '0;
            r_streak    <= '0;
            r_conv      <= 1'b0;
            r_enroll    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend      <= n_pend;
            r_stored    <= n_stored;
            r_streak    <= n_streak;
            r_conv      <= n_conv;
            r_enroll    <= n_enroll;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the boundary token and the verdict payload
    always_ff @(posedge i_clk) begin
        if (w_end) begin
            r_pend_sess   <= i_tok.sess;
            r_pend_enroll <= i_tok.enroll;
            r_pend_dup    <= i_tok.dup;
        end
        r_out_verdict <= n_out_verdict;
        r_out_target  <= n_out_target;
        r_out_count   <= n_out_count;
    end

    assign o_stored           = r_stored;
    assign o_out.valid        = r_out_valid;
    assign o_out.verdict      = r_out_verdict;
    assign o_out.stage_goal   = r_out_target;
    assign o_out.stored_count = r_out_count;

endmodule

[src/efdg_checker.sv]
// ----------------------------------------------------------------------------
// efdg_checker
// Port-level checks of the frame diversity gate, bound to the top level.
// ----------------------------------------------------------------------------
module efdg_checker import efdg_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_in_op,
    input logic               i_in_frame_end,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         i_verdict,
    input logic [COUNT_W-1:0] i_target,
    input logic [COUNT_W-1:0] i_stored
);

    // Stalled verdict holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable({i_verdict, i_target, i_stored}))
        else $error("stalled verdict changed");

    // A frame or session boundary transfer blocks the next input cycle
    a_boundary_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_op == OP_SESSION || i_in_frame_end) |=>
            !i_in_ready)
        else $error("input taken right after a frame boundary");

    // Target count only on convergence
    a_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_verdict != VERDICT_CONVERGED |-> i_target == '0)
        else $error("target stages set without convergence");

    // Convergence targets one stage beyond the held frames
    a_target_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_verdict == VERDICT_CONVERGED |->
            i_target == i_stored + 4'd1)
        else $error("convergence target does not match held frames");

    // A stored frame leaves at least one held
    a_stored_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_verdict == VERDICT_STORED |-> i_stored != '0)
        else $error("frame stored but count is zero");

endmodule

bind enroll_frame_diversity_gate efdg_checker u_efdg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_op        (i_in.op),
    .i_in_frame_end (i_in.frame_end),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_verdict      (o_out.verdict),
    .i_target       (o_out.stage_goal),
    .i_stored       (o_out.stored_count)
);

[tb/efdg_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// efdg_tb_checker
// Watches the pixel, verdict and register channels of the diversity gate,
// predicts every frame verdict and compares each verdict transfer with it.
// ----------------------------------------------------------------------------
module efdg_tb_checker import efdg_pkg::*; #(
    parameter int FRAME_PIXELS = FRAME_PIXELS_DEF,
    parameter int MAX_SLOTS    = MAX_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    efdg_in_if                    i_pix,
    efdg_out_if                   i_verdict,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        t_verdict           verdict;
        logic [COUNT_W-1:0] stage_goal;
        logic [COUNT_W-1:0] stored_count;
    } t_verdict_rec;

    // Verdicts predicted but not yet seen on the output channel
    t_verdict_rec pending_verdicts [$];

    // Shadow of the gate: frame store, per-slot sums and session state
    t_pixel      slot_mem [MAX_SLOTS][FRAME_PIXELS];
    int unsigned diff_sum [MAX_SLOTS];
    int unsigned pix_pos;
    int unsigned held;
    int unsigned streak;
    bit          converged;
    bit          enrolling;

    logic [MIN_DIFF_W-1:0] thr_q4;
    logic [STAGES_W-1:0]   need_stages;
    logic [DUP_W-1:0]      streak_stop;

    // Start a new frame: drop the sums and rewind the pixel position
    task automatic restart_frame();
        for (int s = 0; s < MAX_SLOTS; s++) begin
            diff_sum[s] = 0;
        end
        pix_pos = 0;
    endtask

    task automatic clear_gate_state();
        for (int s = 0; s < MAX_SLOTS; s++) begin
            for (int p = 0; p < FRAME_PIXELS; p++) begin
                slot_mem[s][p] = '0;
            end
        end
        restart_frame();
        held        = 0;
        streak      = 0;
        converged   = 1'b0;
        enrolling   = 1'b0;
        thr_q4      = MIN_DIFF_RST;
        need_stages = MIN_STAGES_RST;
        streak_stop = DUP_STOP_RST;
        pending_verdicts.delete();
    endtask

    // Duplicate when some held slot's mean difference falls below the threshold
    function automatic bit frame_matches_slot(input int unsigned count);
        longint unsigned lhs;
        longint unsigned rhs;
        if (thr_q4 == '0 || held == 0) begin
            return 1'b0;
        end
        rhs = thr_q4;
        rhs = rhs * count;
        for (int s = 0; s < held && s < MAX_SLOTS; s++) begin
            lhs = diff_sum[s];
            lhs = lhs * 16;
            if (lhs < rhs) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Fold one accepted item into the shadow state; queue a verdict at frame end
    task automatic predict_verdict(input logic op, input t_pixel pix, input logic last,
                                   input logic enr);
        t_verdict_rec rec;
        int unsigned  new_pix;
        int unsigned  old_pix;
        new_pix = pix;
        if (op == OP_SESSION) begin
            enrolling = enr;
            held      = 0;
            streak    = 0;
            converged = 1'b0;
            restart_frame();
            return;
        end

        // Pixels past the end of the store are neither compared nor kept
        if (pix_pos < FRAME_PIXELS) begin
            for (int s = 0; s < held && s < MAX_SLOTS; s++) begin
                old_pix = slot_mem[s][pix_pos];
                diff_sum[s] += (new_pix > old_pix) ? new_pix - old_pix : old_pix - new_pix;
            end
            if (held < MAX_SLOTS) begin
                slot_mem[held][pix_pos] = pix;
            end
            pix_pos++;
        end

        if (!last) begin
            return;
        end

        rec.stage_goal = '0;
        if (enrolling && !converged) begin
            if (frame_matches_slot(pix_pos)) begin
                if (streak < STREAK_MAX) begin
                    streak++;
                end
                if (held >= need_stages && held < MAX_SLOTS && streak >= streak_stop) begin
                    converged      = 1'b1;
                    rec.verdict    = VERDICT_CONVERGED;
                    rec.stage_goal = COUNT_W'(held + 1);
                end else begin
                    rec.verdict = VERDICT_RETRY;
                end
            end else begin
                streak = 0;
                if (held < MAX_SLOTS) begin
                    held++;
                    rec.verdict = VERDICT_STORED;
                end else begin
                    rec.verdict = VERDICT_UNSTORED;
                end
            end
        end else begin
            rec.verdict = VERDICT_UNSTORED;
        end
        rec.stored_count = COUNT_W'(held);
        restart_frame();
        pending_verdicts.push_back(rec);
    endtask

    always @(posedge i_clk) begin : watch
        t_verdict_rec want;
        if (!i_rst_n) begin
            clear_gate_state();
        end else begin
            // Compare the verdict transfer first: it never stems from this edge's input
            if (i_verdict.valid && i_verdict.ready) begin
                if (pending_verdicts.size() == 0) begin
                    $error("verdict transfer with nothing predicted: verdict %0d",
                           i_verdict.verdict);
                    o_fail_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (i_verdict.verdict !== want.verdict) begin
                        $error("verdict: expected %0d, got %0d",
                               want.verdict, i_verdict.verdict);
                        o_fail_count++;
                    end
                    if (i_verdict.stage_goal !== want.stage_goal) begin
                        $error("stage_goal: expected %0d, got %0d",
                               want.stage_goal, i_verdict.stage_goal);
                        o_fail_count++;
                    end
                    if (i_verdict.stored_count !== want.stored_count) begin
                        $error("stored_count: expected %0d, got %0d",
                               want.stored_count, i_verdict.stored_count);
                        o_fail_count++;
                    end
                end
            end

            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_DIFF:   thr_q4      = i_cfg_data[MIN_DIFF_W-1:0];
                    CFG_MIN_STAGES: need_stages = i_cfg_data[STAGES_W-1:0];
                    CFG_DUP_STOP:   streak_stop = i_cfg_data[DUP_W-1:0];
                    default: ;
                endcase
            end

            if (i_pix.valid && i_pix.ready) begin
                predict_verdict(i_pix.op, i_pix.pixel, i_pix.frame_end, i_pix.enroll_session);
            end
        end
        o_pending = pending_verdicts.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the enrollment frame diversity gate: fills every slot, runs
// directed frames, then random enroll and verify sessions under several
// register settings and idling patterns; the checker judges each verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import efdg_pkg::*;

    localparam int TB_FRAME_PIXELS = 64;
    localparam int SLOTS           = MAX_SLOTS_DEF;
    localparam int SETTLE_CYCLES   = 2 * SLOTS + 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int RANDOM_ITEMS    = 280;
    localparam int PHASE_ITEMS     = 40;
    localparam int TIMEOUT_NS      = 6_000_000;
    localparam int BUF_DEPTH       = 2 * TB_FRAME_PIXELS;

    typedef enum {SHAPE_NOISY, SHAPE_FRESH, SHAPE_COPY} t_frame_shape;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    efdg_in_if  pix_ch ();
    efdg_out_if verdict_ch ();

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_asks;
    int hold_done;
    int item_count;

    t_pixel frame_buf [BUF_DEPTH];
    t_pixel base_buf  [BUF_DEPTH];

    enroll_frame_diversity_gate #(
        .FRAME_PIXELS (TB_FRAME_PIXELS),
        .MAX_SLOTS    (SLOTS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (pix_ch),
        .o_out      (verdict_ch)
    );

    efdg_tb_checker #(
        .FRAME_PIXELS (TB_FRAME_PIXELS),
        .MAX_SLOTS    (SLOTS)
    ) u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_pix        (pix_ch),
        .i_verdict    (verdict_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Drive verdict ready: random stalls, plus a long hold-off when asked
    initial begin
        verdict_ch.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_asks != hold_done) begin
                verdict_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done++;
            end
            verdict_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        #TIMEOUT_NS;
        $display("tb: failure");
        $finish;
    end

    // Offer one item after random idle cycles and hold it until the transfer
    task automatic push_item(input logic op, input t_pixel pix, input logic last,
                             input logic enr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pix_ch.valid          <= 1'b1;
        pix_ch.op             <= op;
        pix_ch.pixel          <= pix;
        pix_ch.frame_end      <= last;
        pix_ch.enroll_session <= enr;
        do @(posedge clk); while (!pix_ch.ready);
        @(negedge clk);
        item_count++;
    endtask

    task automatic send_session(input logic enr);
        push_item(OP_SESSION, t_pixel'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), enr);
    endtask

    // Stream frame_buf; leave the frame open when finish is clear
    task automatic send_frame(input int len, input bit finish);
        for (int i = 0; i < len; i++) begin
            push_item(OP_PIXEL, frame_buf[i], finish && (i == len - 1),
                      1'($urandom_range(0, 1)));
        end
    endtask

    // Pause the sender until every predicted verdict is out and the gate is quiet
    task automatic drain_verdicts();
        pix_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input int unsigned thr, input int unsigned stages,
                              input int unsigned stop);
        drain_verdicts();
        write_reg(CFG_MIN_DIFF, thr);
        write_reg(CFG_MIN_STAGES, stages);
        write_reg(CFG_DUP_STOP, stop);
    endtask

    // Mostly short frames; now and then one pixel, a full frame or an overlong one
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 1;
        if (r == 1) return TB_FRAME_PIXELS;
        if (r == 2) return TB_FRAME_PIXELS + $urandom_range(1, 6);
        return $urandom_range(2, 12);
    endfunction

    task automatic randomize_frame();
        for (int i = 0; i < BUF_DEPTH; i++) begin
            frame_buf[i] = t_pixel'($urandom_range(0, 255));
        end
    endtask

    // Build the next frame of a session from the base impression
    task automatic shape_frame(input t_frame_shape shape, input int amp);
        int v;
        for (int i = 0; i < BUF_DEPTH; i++) begin
            case (shape)
                SHAPE_NOISY: begin
                    v = int'(base_buf[i]) + int'($urandom_range(0, 2 * amp)) - amp;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                    frame_buf[i] = t_pixel'(v);
                end
                SHAPE_FRESH: frame_buf[i] = t_pixel'($urandom_range(0, 255));
                default:     frame_buf[i] = base_buf[i];
            endcase
        end
    endtask

    // One session: a base frame, then near copies, fresh frames and exact copies
    task automatic run_session();
        int           base_len;
        int           len;
        int           frames;
        int           amp;
        int           r;
        t_frame_shape shape;
        send_session($urandom_range(0, 7) != 0);
        base_len = pick_length();
        for (int i = 0; i < BUF_DEPTH; i++) begin
            base_buf[i] = t_pixel'($urandom_range(0, 255));
        end
        frames = $urandom_range(3, 12);
        for (int f = 0; f < frames; f++) begin
            len = ($urandom_range(0, 5) == 0) ? pick_length() : base_len;
            r   = $urandom_range(0, 9);
            if (f == 0 || r == 9) begin
                shape = SHAPE_COPY;
            end else if (r < 6) begin
                shape = SHAPE_NOISY;
            end else begin
                shape = SHAPE_FRESH;
            end
            case ($urandom_range(0, 4))
                0:       amp = 0;
                1:       amp = 1;
                2:       amp = 3;
                3:       amp = 8;
                default: amp = 24;
            endcase
            shape_frame(shape, amp);
            // A fresh frame may become the new base, as if the finger moved
            if (shape == SHAPE_FRESH && $urandom_range(0, 1) == 1) begin
                for (int i = 0; i < BUF_DEPTH; i++) begin
                    base_buf[i] = frame_buf[i];
                end
            end
            // Drop the session now and then in the middle of a frame
            if ($urandom_range(0, 24) == 0) begin
                send_frame(len / 2 + 1, 1'b0);
                return;
            end
            send_frame(len, 1'b1);
        end
    endtask

    task automatic enter_phase(input int phase);
        case (phase % 7)
            0:       set_config(MIN_DIFF_RST, MIN_STAGES_RST, DUP_STOP_RST);
            1:       set_config(4095, 8, 7);
            2:       set_config(1, 1, 1);
            3:       set_config(0, 3, 2);
            4:       set_config($urandom_range(16, 400), $urandom_range(1, 8),
                                $urandom_range(1, 7));
            5:       set_config(200, 0, 0);
            default: set_config($urandom_range(0, 4095), $urandom_range(0, 15),
                                $urandom_range(0, 7));
        endcase
    endtask

    initial begin : stimulus
        int phase;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_idx               <= CFG_MIN_DIFF;
        cfg_data              <= '0;
        pix_ch.valid          <= 1'b0;
        pix_ch.op             <= OP_PIXEL;
        pix_ch.pixel          <= '0;
        pix_ch.frame_end      <= 1'b0;
        pix_ch.enroll_session <= 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 78;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill every slot with full frames, duplicate check off; the last is unstored
        set_config(0, MIN_STAGES_RST, DUP_STOP_RST);
        send_session(1'b1);
        // Hold off the receiver while the frames keep coming
        hold_asks++;
        repeat (SLOTS + 1) begin
            randomize_frame();
            send_frame(TB_FRAME_PIXELS, 1'b1);
        end
        // Duplicate with a full store: retry
        set_config(4095, MIN_STAGES_RST, DUP_STOP_RST);
        randomize_frame();
        send_frame(TB_FRAME_PIXELS, 1'b1);

        // Directed: store, retry, converge, then delivered while converged
        set_config(MIN_DIFF_RST, 1, DUP_STOP_RST);
        send_session(1'b1);
        frame_buf[0] = 8'd0;
        frame_buf[1] = 8'd255;
        frame_buf[2] = 8'd128;
        frame_buf[3] = 8'd1;
        repeat (3) send_frame(4, 1'b1);
        frame_buf[0] = 8'd255;
        frame_buf[1] = 8'd0;
        frame_buf[2] = 8'd1;
        frame_buf[3] = 8'd254;
        send_frame(4, 1'b1);
        // Verify session: delivered unstored
        send_session(1'b0);
        send_frame(1, 1'b1);
        // Unfinished frame dropped by a new session
        send_session(1'b1);
        frame_buf[0] = 8'd0;
        frame_buf[1] = 8'd0;
        send_frame(2, 1'b0);
        send_session(1'b1);
        frame_buf[0] = 8'd255;
        send_frame(1, 1'b1);

        // Random sessions across register settings and idling patterns
        item_count = 0;
        phase      = 0;
        while (item_count < RANDOM_ITEMS) begin
            if (item_count >= phase * PHASE_ITEMS) begin
                enter_phase(phase);
                if (phase == 2 || phase == 6) begin
                    hold_asks++;
                end
                phase++;
            end
            if (item_count < RANDOM_ITEMS / 3) begin
                send_idle_pct = 27;
                recv_idle_pct = 78;
            end else if (item_count < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 78;
                recv_idle_pct = 27;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_session();
        end

        drain_verdicts();
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
